FILE: sv/v3n_pkg.sv
// Package with shared types and constants of the vector normalizer.
package v3n_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int UNIT_WIDTH = 32;
  localparam int UNIT_FRAC = 30;

  // Input beat: three signed Q16.16 components.
  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] in_x;
    logic signed [COORD_WIDTH_DEF-1:0] in_y;
    logic signed [COORD_WIDTH_DEF-1:0] in_z;
  } v3n_in_t;

  // Output beat: unit components in Q2.30, length and zero flag.
  typedef struct packed {
    logic signed [UNIT_WIDTH-1:0] out_x;
    logic signed [UNIT_WIDTH-1:0] out_y;
    logic signed [UNIT_WIDTH-1:0] out_z;
    logic [COORD_WIDTH_DEF-1:0] length;
    logic zero_length;
  } v3n_out_t;

endpackage

FILE: sv/v3n_sqrt_stage.sv
// One pipelined step of the floor square root: two radicand bits per stage.
module v3n_sqrt_stage
  import v3n_pkg::*;
#(
  parameter int RW = 64,
  parameter int SW = 130
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          vin,
  input  logic [RW-1:0] root_in,
  input  logic [RW+1:0] rem_in,
  input  logic [1:0]    pair,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [RW-1:0] root,
  output logic [RW+1:0] rem,
  output logic [SW-1:0] side
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW-1:0] root_next;
  logic [RW+1:0] rem_next;

  // Compare the shifted remainder against 4*root+1.
  always_comb begin
    rem_sh = {rem_in[RW-1:0], pair};
    trial  = {root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root_in[RW-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root_in[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root <= root_next;
      rem  <= rem_next;
      side <= side_in;
    end
  end

endmodule

FILE: sv/v3n_div_stage.sv
// One pipelined step of the three restoring dividers sharing one divisor.
module v3n_div_stage
  import v3n_pkg::*;
#(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 8,
  parameter bit FIRST = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            vin,
  input  logic [DW-1:0]   len,
  input  logic [3*DW-1:0] rem_in,
  input  logic [3*QW-1:0] quo_in,
  input  logic [SW-1:0]   side_in,
  output logic            vout,
  output logic [DW-1:0]   len_o,
  output logic [3*DW-1:0] rem,
  output logic [3*QW-1:0] quo,
  output logic [SW-1:0]   side
);

  logic [3*DW-1:0] rem_next;
  logic [3*QW-1:0] quo_next;
  logic [DW:0]     r_sh;

  // Each lane shifts (except the first step), compares and subtracts.
  always_comb begin
    r_sh = '0;
    rem_next = '0;
    quo_next = '0;
    for (int k = 0; k < 3; k++) begin
      if (FIRST) begin
        r_sh = {1'b0, rem_in[k*DW +: DW]};
      end else begin
        r_sh = {rem_in[k*DW +: DW], 1'b0};
      end
      if (r_sh >= {1'b0, len}) begin
        rem_next[k*DW +: DW] = DW'(r_sh - {1'b0, len});
        quo_next[k*QW +: QW] = {quo_in[k*QW +: QW-1], 1'b1};
      end else begin
        rem_next[k*DW +: DW] = r_sh[DW-1:0];
        quo_next[k*QW +: QW] = {quo_in[k*QW +: QW-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_o <= len;
      rem   <= rem_next;
      quo   <= quo_next;
      side  <= side_in;
    end
  end

endmodule

FILE: sv/vector3_normalize.sv
// Top level of the pipelined 3D vector normalizer.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  v3n_in_t
//  out      output     out_valid/out_stall v3n_out_t
//
// Pipeline stages: squares, sum, one root stage per root bit (COORD_WIDTH + 1),
// one divider stage per quotient bit (UNIT_FRAC + 1).
// One beat is accepted every cycle; the whole pipeline holds on out_stall.
// Reset clears only the valid bits; nothing is kept between items.
module vector3_normalize
  import v3n_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  v3n_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output v3n_out_t out_data
);

  localparam int CW  = COORD_WIDTH_DEF;
  localparam int RW  = CW + 1;          // root bits (length < 2^CW, extra for sqrt)
  localparam int NP  = RW;              // radicand pairs
  localparam int SQW = 2 * NP;          // radicand width
  localparam int MSW = 3 * CW + 3;      // magnitudes and signs
  localparam int NQ  = UNIT_FRAC + 1;   // quotient bits
  localparam int QW  = UNIT_WIDTH;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: magnitudes and squares.
  logic          v1;
  logic [CW-1:0] mag1 [3];
  logic [2:0]    neg1;
  logic [2*CW-1:0] sq1 [3];
  logic [CW-1:0] mag_c [3];
  logic [CW-1:0] raw_c [3];

  always_comb begin
    raw_c[0] = in_data.in_x[CW-1:0];
    raw_c[1] = in_data.in_y[CW-1:0];
    raw_c[2] = in_data.in_z[CW-1:0];
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = raw_c[k][CW-1] ? (~raw_c[k] + CW'(1)) : raw_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag1[k] <= mag_c[k];
        neg1[k] <= raw_c[k][CW-1];
        sq1[k]  <= (2*CW)'(mag_c[k]) * (2*CW)'(mag_c[k]);
      end
    end
  end

  // Stage 2: sum of squares.
  logic           v2;
  logic [SQW-1:0] sum2;
  logic [MSW-1:0] side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum2  <= SQW'(sq1[0]) + SQW'(sq1[1]) + SQW'(sq1[2]);
      side2 <= {neg1, mag1[2], mag1[1], mag1[0]};
    end
  end

  // Root pipeline: radicand travels in the side band with the magnitudes.
  localparam int RSW = MSW + SQW;
  logic           sv   [NP+1];
  logic [RW-1:0]  sroot[NP+1];
  logic [RW+1:0]  srem [NP+1];
  logic [RSW-1:0] sside[NP+1];

  assign sv[0]    = v2;
  assign sroot[0] = '0;
  assign srem[0]  = '0;
  assign sside[0] = {side2, sum2};

  for (genvar i = 0; i < NP; i++) begin : g_sqrt
    v3n_sqrt_stage #(.RW(RW), .SW(RSW)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vin    (sv[i]),
      .root_in(sroot[i]),
      .rem_in (srem[i]),
      .pair   (sside[i][2*(NP-1-i) +: 2]),
      .side_in(sside[i]),
      .vout   (sv[i+1]),
      .root   (sroot[i+1]),
      .rem    (srem[i+1]),
      .side   (sside[i+1])
    );
  end

  // Divider pipeline, divisor is the length (fits CW bits).
  localparam int DW  = CW + 1;
  localparam int DSW = 4;
  logic            dv   [NQ+1];
  logic [DW-1:0]   dlen [NQ+1];
  logic [3*DW-1:0] drem [NQ+1];
  logic [3*QW-1:0] dquo [NQ+1];
  logic [DSW-1:0]  dside[NQ+1];
  logic [MSW-1:0]  mside;

  assign mside   = sside[NP][RSW-1:SQW];
  assign dv[0]   = sv[NP];
  assign dlen[0] = DW'(sroot[NP]);
  assign drem[0] = {1'b0, mside[3*CW-1:2*CW], 1'b0, mside[2*CW-1:CW],
                    1'b0, mside[CW-1:0]};
  assign dquo[0] = '0;
  assign dside[0] = {(sroot[NP] == '0), mside[MSW-1:3*CW]};

  for (genvar j = 0; j < NQ; j++) begin : g_div
    v3n_div_stage #(.DW(DW), .QW(QW), .SW(DSW), .FIRST(j == 0)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vin    (dv[j]),
      .len    (dlen[j]),
      .rem_in (drem[j]),
      .quo_in (dquo[j]),
      .side_in(dside[j]),
      .vout   (dv[j+1]),
      .len_o  (dlen[j+1]),
      .rem    (drem[j+1]),
      .quo    (dquo[j+1]),
      .side   (dside[j+1])
    );
  end

  // Output: apply signs, force zeros for a zero-length vector.
  logic zl;
  logic [QW-1:0] q [3];
  assign zl = dside[NQ][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = dside[NQ][k] ? (QW'(0) - dquo[NQ][k*QW +: QW]) : dquo[NQ][k*QW +: QW];
      if (zl) begin
        q[k] = '0;
      end
    end
  end

  assign out_valid            = dv[NQ];
  assign out_data.out_x       = q[0];
  assign out_data.out_y       = q[1];
  assign out_data.out_z       = q[2];
  assign out_data.length      = COORD_WIDTH_DEF'(dlen[NQ][CW-1:0]);
  assign out_data.zero_length = zl;

  // A zero-length beat reports a zero length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_length |-> out_data.length == '0)
    else $error("zero-length beat with nonzero length");

  // The unit x component never exceeds one in magnitude.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.out_x) <= 32'sh4000_0000 &&
                   $signed(out_data.out_x) >= -32'sh4000_0000))
    else $error("unit x out of range");

  // A stalled output keeps its valid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped during stall");

endmodule
